[design/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with reverse.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0]         t_count;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_HEAD = 3'd0,
        KIND_PUSH_TAIL = 3'd1,
        KIND_POP_HEAD  = 3'd2,
        KIND_POP_TAIL  = 3'd3,
        KIND_REVERSE   = 3'd4
    } t_kind;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load;
    } t_cell_ctl;

endpackage

[design/bdq_cell.sv]
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque chain: load, take from the lower or upper
// neighbor, or hold.
// ----------------------------------------------------------------------------
module bdq_cell (
    input  logic                i_clk,
    input  bdq_pkg::t_cell_ctl  i_ctl,
    input  bdq_pkg::t_data      i_load_value,
    input  bdq_pkg::t_data      i_lower,
    input  bdq_pkg::t_data      i_upper,
    output bdq_pkg::t_data      o_data
);
    import bdq_pkg::*;

    t_data r_data;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load) begin
            r_data <= i_load_value;
        end else if (i_ctl.shift_up) begin
            r_data <= i_lower;
        end else if (i_ctl.shift_down) begin
            r_data <= i_upper;
        end else begin
            r_data <= r_data;
        end
    end

    assign o_data = r_data;

endmodule

[design/bounded_deque_with_reverse_core.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_reverse_core
// Double-ended queue of signed 32-bit values with constant-time reverse.
//
// One operation is accepted per clock: start is taken whenever busy is low,
// and busy never rises. Each beat gives one result on o_valid in the cycle
// after acceptance; the receiver cannot stall, so results must be
// captured on the strobe. The values sit in a row of CAPACITY cells kept in
// order from the low end: an insert at the low end shifts the whole row up
// in that cycle, a removal there shifts it down, and the high end is written
// or read at the cell that the count selects. Reverse only flips which end
// acts as the head; reversing an empty queue changes nothing.
// ----------------------------------------------------------------------------
module bounded_deque_with_reverse_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            i_kind,
    input  bdq_pkg::t_data        i_item_value,
    output logic                  o_valid,
    output logic                  o_success,
    output bdq_pkg::t_data        o_removed_value,
    output bdq_pkg::t_count       o_element_count
);
    import bdq_pkg::*;

    t_count    r_count, n_count;
    logic      r_rev, n_rev;
    logic      r_valid;
    logic      r_success, n_success;
    t_data     r_removed, n_removed;

    t_data     cell_data [CAPACITY];
    t_cell_ctl cell_ctl  [CAPACITY];
    t_data     tail_data;
    t_count    last_idx;
    logic      accept;
    logic      is_full;
    logic      is_empty;
    logic      push_low, push_high, pop_low;
    logic      at_low;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (r_count == t_count'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign last_idx = r_count - t_count'(1);

    always_comb begin
        tail_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (last_idx == t_count'(i)) begin
                tail_data = tail_data | cell_data[i];
            end
        end
    end

    always_comb begin
        push_low  = 1'b0;
        push_high = 1'b0;
        pop_low   = 1'b0;
        at_low    = 1'b0;
        n_count   = r_count;
        n_rev     = r_rev;
        n_success = 1'b0;
        n_removed = '0;
        if (accept) begin
            unique case (t_kind'(i_kind))
                KIND_PUSH_HEAD, KIND_PUSH_TAIL: begin
                    at_low = ((t_kind'(i_kind) == KIND_PUSH_HEAD) != r_rev);
                    if (!is_full) begin
                        push_low  = at_low;
                        push_high = !at_low;
                        n_count   = r_count + t_count'(1);
                        n_success = 1'b1;
                    end
                end
                KIND_POP_HEAD, KIND_POP_TAIL: begin
                    at_low = ((t_kind'(i_kind) == KIND_POP_HEAD) != r_rev);
                    if (!is_empty) begin
                        pop_low   = at_low;
                        n_count   = r_count - t_count'(1);
                        n_success = 1'b1;
                        n_removed = at_low ? cell_data[0] : tail_data;
                    end
                end
                KIND_REVERSE: begin
                    n_rev     = is_empty ? r_rev : !r_rev;
                    n_success = 1'b1;
                end
                default: begin
                    n_success = 1'b0;
                end
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign cell_ctl[g].shift_up   = push_low;
        assign cell_ctl[g].shift_down = pop_low;
        assign cell_ctl[g].load       = push_high && (r_count == t_count'(g));

        bdq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl[g]),
            .i_load_value (i_item_value),
            .i_lower      ((g == 0) ? i_item_value : cell_data[(g == 0) ? 0 : g - 1]),
            .i_upper      ((g == CAPACITY - 1) ? cell_data[g]
                                               : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data       (cell_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rev   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_rev   <= n_rev;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_success <= n_success;
        r_removed <= n_removed;
    end

    assign o_valid         = r_valid;
    assign o_success       = r_success;
    assign o_removed_value = r_removed;
    assign o_element_count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("element count above capacity");

    a_beat_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("accepted beat gave no result");

    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_success) |-> (o_removed_value == '0))
        else $error("failed operation returned a value");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_success) |-> (o_element_count == $past(r_count)))
        else $error("failed operation changed the count");

endmodule
